// File: hw/rtl/page_framebuffer_text_plotter_unit_assert.svh
// Assertion macros shared by the plotter RTL.
`ifndef PAGE_FRAMEBUFFER_TEXT_PLOTTER_UNIT_ASSERT_SVH
`define PAGE_FRAMEBUFFER_TEXT_PLOTTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PFTP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pftp assertion failed");

// Next-cycle implication, disabled in reset.
`define PFTP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pftp assertion failed");

`endif

// File: hw/rtl/pftp_pkg.sv
// Shared types and constants for the page framebuffer text plotter.
package pftp_pkg;

   localparam int MAX_ADDR_W = 15;

   localparam logic [1:0] CMD_PIXEL = 2'd0;
   localparam logic [1:0] CMD_GLYPH = 2'd1;
   localparam logic [1:0] CMD_FILL  = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam logic [3:0] LAST_GLYPH_STEP = 4'd11;

   typedef struct packed {
      logic                  hit;
      logic [MAX_ADDR_W-1:0] addr;
      logic [7:0]            mask;
      logic [7:0]            data;
   } op_type;

endpackage

// File: hw/rtl/pftp_op_gen.sv
// Byte operation generator: address, mask, data and clip for one page byte.
module pftp_op_gen #(
   parameter int WIDTH_PX  = 128,
   parameter int HEIGHT_PX = 64
) (
   input  logic [1:0]         cmd,
   input  logic signed [9:0]  pos_x,
   input  logic signed [9:0]  pos_y,
   input  logic               pixel_on,
   input  logic [7:0]         char_code,
   input  logic [3:0]         step,
   output pftp_pkg::op_type   op
);
   import pftp_pkg::*;

   localparam int NPAGES = HEIGHT_PX / 8;

   logic [2:0]  col;
   logic        half;
   logic [6:0]  colbits;
   logic [6:0]  rowmask;
   logic [15:0] win_mask;
   logic [15:0] win_data;
   logic [10:0] x_s;
   logic [7:0]  page_s;
   logic        x_ok;
   logic        page_ok;

   function automatic logic [6:0] glyph_col(input logic [7:0] code, input logic [2:0] c);
      logic [7:0]  k;
      logic [39:0] g;
      k = code;
      if (code >= 8'h61 && code <= 8'h7A) begin
         k = code - 8'h20;
      end
      case (k)
         8'h21: g = {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
         8'h2D: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
         8'h2E: g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
         8'h2F: g = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02};
         8'h30: g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
         8'h31: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
         8'h32: g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
         8'h33: g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
         8'h34: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
         8'h35: g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
         8'h36: g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
         8'h37: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
         8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
         8'h39: g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
         8'h3A: g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
         8'h41: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
         8'h42: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
         8'h43: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
         8'h44: g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
         8'h45: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
         8'h46: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
         8'h47: g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
         8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
         8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
         8'h4A: g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
         8'h4B: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
         8'h4C: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
         8'h4D: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
         8'h4E: g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
         8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
         8'h50: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
         8'h51: g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
         8'h52: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
         8'h53: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
         8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
         8'h55: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
         8'h56: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
         8'h57: g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
         8'h58: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
         8'h59: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
         8'h5A: g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
         8'h5F: g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h40};
         default: g = 40'd0;
      endcase
      case (c)
         3'd0: glyph_col = g[38:32];
         3'd1: glyph_col = g[30:24];
         3'd2: glyph_col = g[22:16];
         3'd3: glyph_col = g[14:8];
         3'd4: glyph_col = g[6:0];
         default: glyph_col = 7'd0;
      endcase
   endfunction

   always_comb begin
      col  = step[3:1];
      half = step[0];
      if (cmd == CMD_GLYPH) begin
         colbits = glyph_col(char_code, col);
         rowmask = 7'h7F;
      end else begin
         colbits = {6'd0, pixel_on};
         rowmask = 7'h01;
      end
      win_mask = {9'd0, rowmask} << pos_y[2:0];
      win_data = {9'd0, colbits} << pos_y[2:0];
      x_s      = {pos_x[9], pos_x} + {8'd0, col};
      page_s   = {pos_y[9], pos_y[9:3]} + {7'd0, half};
      x_ok     = !x_s[10] && (x_s < 11'(WIDTH_PX));
      page_ok  = !page_s[7] && (page_s < 8'(NPAGES));
      op.hit   = x_ok && page_ok;
      op.mask  = half ? win_mask[15:8] : win_mask[7:0];
      op.data  = half ? win_data[15:8] : win_data[7:0];
      op.addr  = MAX_ADDR_W'(x_s[8:0]) + MAX_ADDR_W'(page_s[4:0]) * MAX_ADDR_W'(WIDTH_PX);
   end

endmodule

// File: hw/rtl/page_framebuffer_text_plotter_unit.sv
// Top level: page framebuffer with 5x7 text plotter, one byte RMW unit.
// A glyph cell writes 12 bytes, each read and then written back via one read-modify-write
// port; a fill writes the store one byte a cycle.
// One request at a time; a new one is accepted while the previous result waits.
// Reset: a clearing pass zeroes the whole store; no request is taken until it ends.
`include "page_framebuffer_text_plotter_unit_assert.svh"
module page_framebuffer_text_plotter_unit #(
   parameter int WIDTH_PX  = 128,
   parameter int HEIGHT_PX = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_cmd,
   input  logic signed [9:0] req_pos_x,
   input  logic signed [9:0] req_pos_y,
   input  logic              req_pixel_on,
   input  logic [7:0]        req_char_code,
   input  logic [9:0]        req_byte_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_read_data,
   output logic              rsp_is_read
);
   import pftp_pkg::*;

   localparam int STORE_BYTES = WIDTH_PX * (HEIGHT_PX / 8);
   localparam int AW          = $clog2(STORE_BYTES);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_CALC  = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [7:0] mem [STORE_BYTES];

   logic [2:0]        state_ff, state_in;
   logic              init_ff, init_in;
   logic [3:0]        step_ff, step_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic signed [9:0] pos_x_ff, pos_x_in;
   logic signed [9:0] pos_y_ff, pos_y_in;
   logic              on_ff, on_in;
   logic [7:0]        code_ff, code_in;
   logic [9:0]        index_ff, index_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [7:0]        fill_ff, fill_in;
   op_type            op_ff, op_in;
   logic [7:0]        rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_is_read_ff, rsp_is_read_in;

   op_type                gen_op;
   logic [3:0]            gen_step;
   logic                  req_accept;
   logic                  rsp_free;
   logic                  last_step;
   logic                  in_range;
   logic [MAX_ADDR_W-1:0] index_wide;
   logic                  mem_we;
   logic                  mem_re;
   logic [AW-1:0]         mem_wa;
   logic [AW-1:0]         mem_ra;
   logic [7:0]            mem_wd;

   pftp_op_gen #(
      .WIDTH_PX  (WIDTH_PX),
      .HEIGHT_PX (HEIGHT_PX)
   ) u_op_gen (
      .cmd       (cmd_ff),
      .pos_x     (pos_x_ff),
      .pos_y     (pos_y_ff),
      .pixel_on  (on_ff),
      .char_code (code_ff),
      .step      (gen_step),
      .op        (gen_op)
   );

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_accept    = req_valid && !req_stall;
   assign rsp_free      = !rsp_valid_ff || !rsp_stall;
   assign gen_step      = (state_ff == ST_WRITE) ? step_ff + 4'd1 : 4'd0;
   assign last_step     = (cmd_ff == CMD_GLYPH) ? (step_ff == LAST_GLYPH_STEP) : 1'b1;
   assign index_wide    = MAX_ADDR_W'(index_ff);
   assign in_range      = index_wide < MAX_ADDR_W'(STORE_BYTES);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_is_read   = rsp_is_read_ff;

   always_comb begin
      state_in       = state_ff;
      init_in        = init_ff;
      step_in        = step_ff;
      cmd_in         = cmd_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      on_in          = on_ff;
      code_in        = code_ff;
      index_in       = index_ff;
      clr_addr_in    = clr_addr_ff;
      fill_in        = fill_ff;
      op_in          = op_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      rsp_is_read_in = rsp_is_read_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_wa         = op_ff.addr[AW-1:0];
      mem_ra         = op_ff.addr[AW-1:0];
      mem_wd         = (rd_data_ff & ~op_ff.mask) | (op_ff.data & op_ff.mask);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in   = req_cmd;
               pos_x_in = req_pos_x;
               pos_y_in = req_pos_y;
               on_in    = req_pixel_on;
               code_in  = req_char_code;
               index_in = req_byte_index;
               step_in  = 4'd0;
               unique case (req_cmd)
                  CMD_FILL: begin
                     fill_in     = req_pixel_on ? 8'hFF : 8'h00;
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  CMD_READ: state_in = ST_FETCH;
                  default:  state_in = ST_CALC;
               endcase
            end
         end
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_wa      = clr_addr_ff;
            mem_wd      = fill_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(STORE_BYTES - 1)) begin
               state_in = init_ff ? ST_IDLE : ST_DONE;
               init_in  = 1'b0;
            end
         end
         ST_FETCH: begin
            mem_re   = in_range;
            mem_ra   = index_wide[AW-1:0];
            state_in = ST_DONE;
         end
         ST_CALC: begin
            op_in    = gen_op;
            state_in = ST_READ;
         end
         ST_READ: begin
            mem_re   = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            mem_we = op_ff.hit;
            if (last_step) begin
               state_in = ST_DONE;
            end else begin
               step_in  = step_ff + 4'd1;
               op_in    = gen_op;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_is_read_in = (cmd_ff == CMD_READ);
               rsp_data_in    = (cmd_ff == CMD_READ && in_range) ? rd_data_ff : 8'h00;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         init_ff      <= 1'b1;
         clr_addr_ff  <= '0;
         fill_ff      <= 8'h00;
         step_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         clr_addr_ff  <= clr_addr_in;
         fill_ff      <= fill_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      pos_x_ff       <= pos_x_in;
      pos_y_ff       <= pos_y_in;
      on_ff          <= on_in;
      code_ff        <= code_in;
      index_ff       <= index_in;
      op_ff          <= op_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_is_read_ff <= rsp_is_read_in;
   end

   `PFTP_ASSERT_IMP(a_step_bound, clock, reset, (state_ff == ST_READ || state_ff == ST_WRITE), (step_ff <= LAST_GLYPH_STEP))
   `PFTP_ASSERT_IMP(a_pixel_mask, clock, reset, (state_ff == ST_WRITE && cmd_ff == CMD_PIXEL), $onehot(op_ff.mask))
   `PFTP_ASSERT_IMP(a_no_clip_write, clock, reset, (state_ff == ST_WRITE && !op_ff.hit), !mem_we)
   `PFTP_ASSERT_NXT(a_done_loads, clock, reset, (state_ff == ST_DONE && rsp_free), (rsp_valid_ff && state_ff == ST_IDLE))

endmodule

// File: tb/tb.sv
// Self-checking testbench for the page framebuffer text plotter unit.
`timescale 1ns / 1ps

module tb;
   import pftp_pkg::*;

   localparam int SCREEN_W   = 128;
   localparam int SCREEN_H   = 64;
   localparam int STORE_SIZE = SCREEN_W * SCREEN_H / 8;

   typedef struct {
      logic [1:0]        cmd;
      logic signed [9:0] pos_x;
      logic signed [9:0] pos_y;
      logic              pixel_on;
      logic [7:0]        char_code;
      logic [9:0]        byte_index;
   } plot_request_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       is_read;
   } plot_response_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_cmd;
   logic signed [9:0] req_pos_x;
   logic signed [9:0] req_pos_y;
   logic              req_pixel_on;
   logic [7:0]        req_char_code;
   logic [9:0]        req_byte_index;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [7:0]        rsp_read_data;
   logic              rsp_is_read;

   logic [7:0]        shadow_frame [STORE_SIZE];
   plot_response_type pending_rsp [$];

   int err_count    = 0;
   int rsp_checked  = 0;
   int cmd_count [4] = '{0, 0, 0, 0};
   bit req_gaps     = 1'b0;
   bit rsp_gaps     = 1'b0;
   int rsp_hold_len = 0;
   int last_x       = 0;
   int last_y       = 0;

   page_framebuffer_text_plotter_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pixel_on   (req_pixel_on),
      .req_char_code  (req_char_code),
      .req_byte_index (req_byte_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_is_read    (rsp_is_read)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic void set_pixel(input int px, input int py, input logic on);
      int idx;
      if (px < 0 || px >= SCREEN_W || py < 0 || py >= SCREEN_H) return;
      idx = px + (py / 8) * SCREEN_W;
      shadow_frame[idx][py % 8] = on;
   endfunction

   function automatic plot_response_type apply_request(input plot_request_type r);
      plot_response_type rsp;
      int px, py;
      logic [7:0]  ch;
      logic [39:0] cols;
      logic [7:0]  bits;
      rsp = '0;
      px = int'(r.pos_x);
      py = int'(r.pos_y);
      case (r.cmd)
         CMD_PIXEL: set_pixel(px, py, r.pixel_on);
         CMD_GLYPH: begin
            ch = r.char_code;
            if (ch >= "a" && ch <= "z") ch = ch - 8'h20;
            case (ch)
               "!": cols = 40'h00005F0000;
               "-": cols = 40'h0808080808;
               ".": cols = 40'h0060600000;
               "/": cols = 40'h2010080402;
               "0": cols = 40'h3E5149453E;
               "1": cols = 40'h00427F4000;
               "2": cols = 40'h4261514946;
               "3": cols = 40'h2141454B31;
               "4": cols = 40'h1814127F10;
               "5": cols = 40'h2745454539;
               "6": cols = 40'h3C4A494930;
               "7": cols = 40'h0171090503;
               "8": cols = 40'h3649494936;
               "9": cols = 40'h064949291E;
               ":": cols = 40'h0036360000;
               "A": cols = 40'h7E1111117E;
               "B": cols = 40'h7F49494936;
               "C": cols = 40'h3E41414122;
               "D": cols = 40'h7F4141221C;
               "E": cols = 40'h7F49494941;
               "F": cols = 40'h7F09090901;
               "G": cols = 40'h3E4149497A;
               "H": cols = 40'h7F0808087F;
               "I": cols = 40'h00417F4100;
               "J": cols = 40'h2040413F01;
               "K": cols = 40'h7F08142241;
               "L": cols = 40'h7F40404040;
               "M": cols = 40'h7F020C027F;
               "N": cols = 40'h7F0408107F;
               "O": cols = 40'h3E4141413E;
               "P": cols = 40'h7F09090906;
               "Q": cols = 40'h3E4151215E;
               "R": cols = 40'h7F09192946;
               "S": cols = 40'h4649494931;
               "T": cols = 40'h01017F0101;
               "U": cols = 40'h3F4040403F;
               "V": cols = 40'h1F2040201F;
               "W": cols = 40'h3F4038403F;
               "X": cols = 40'h6314081463;
               "Y": cols = 40'h0708700807;
               "Z": cols = 40'h6151494543;
               "_": cols = 40'h4040404040;
               default: cols = '0;
            endcase
            for (int col = 0; col < 6; col++) begin
               bits = (col < 5) ? cols[39 - 8 * col -: 8] : 8'h00;
               for (int row = 0; row < 7; row++)
                  set_pixel(px + col, py + row, bits[row]);
            end
         end
         CMD_FILL: foreach (shadow_frame[i]) shadow_frame[i] = {8{r.pixel_on}};
         CMD_READ: begin
            rsp.read_data = (r.byte_index < STORE_SIZE) ? shadow_frame[r.byte_index] : 8'h00;
            rsp.is_read   = 1'b1;
         end
      endcase
      return rsp;
   endfunction

   function automatic plot_request_type random_fields();
      plot_request_type r;
      r.cmd        = 2'($urandom_range(0, 3));
      r.pos_x      = 10'($urandom());
      r.pos_y      = 10'($urandom());
      r.pixel_on   = 1'($urandom_range(0, 1));
      r.char_code  = 8'($urandom());
      r.byte_index = 10'($urandom());
      return r;
   endfunction

   task automatic send_request(input plot_request_type r);
      @(negedge clock);
      if (req_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= r.cmd;
      req_pos_x      <= r.pos_x;
      req_pos_y      <= r.pos_y;
      req_pixel_on   <= r.pixel_on;
      req_char_code  <= r.char_code;
      req_byte_index <= r.byte_index;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(apply_request(r));
      cmd_count[r.cmd]++;
   endtask

   task automatic wait_all_done();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic do_pixel(input int px, input int py, input logic on);
      plot_request_type r;
      r = random_fields();
      r.cmd      = CMD_PIXEL;
      r.pos_x    = px[9:0];
      r.pos_y    = py[9:0];
      r.pixel_on = on;
      send_request(r);
   endtask

   task automatic do_glyph(input int px, input int py, input logic [7:0] code);
      plot_request_type r;
      r = random_fields();
      r.cmd       = CMD_GLYPH;
      r.pos_x     = px[9:0];
      r.pos_y     = py[9:0];
      r.char_code = code;
      send_request(r);
   endtask

   task automatic do_fill(input logic on);
      plot_request_type r;
      r = random_fields();
      r.cmd      = CMD_FILL;
      r.pixel_on = on;
      send_request(r);
   endtask

   task automatic do_read(input int idx);
      plot_request_type r;
      r = random_fields();
      r.cmd        = CMD_READ;
      r.byte_index = idx[9:0];
      send_request(r);
   endtask

   task automatic test_cleared_store();
      do_read(0);
      do_read(STORE_SIZE - 1);
      do_read(int'($urandom_range(1, STORE_SIZE - 2)));
      wait_all_done();
   endtask

   task automatic test_pixel_edges();
      do_pixel(0, 0, 1'b1);
      do_pixel(SCREEN_W - 1, SCREEN_H - 1, 1'b1);
      do_pixel(-1, 0, 1'b1);
      do_pixel(SCREEN_W, SCREEN_H - 1, 1'b1);
      do_pixel(0, SCREEN_H, 1'b1);
      do_pixel(0, -1, 1'b1);
      do_pixel(-512, -512, 1'b1);
      do_pixel(511, 511, 1'b1);
      do_read(0);
      do_read(STORE_SIZE - 1);
      wait_all_done();
   endtask

   task automatic test_glyph_cells();
      do_glyph(8, 0, "A");
      do_glyph(14, 0, "a");
      do_glyph(20, 5, "0");
      do_glyph(-2, -3, "!");
      do_glyph(SCREEN_W - 4, SCREEN_H - 4, "Z");
      do_read(9);
      do_read(20 + SCREEN_W);
      do_read(STORE_SIZE - 1);
      do_glyph(8, 0, 8'hC8);
      do_read(9);
      wait_all_done();
   endtask

   task automatic test_fill_store();
      do_fill(1'b1);
      do_glyph(0, 0, " ");
      do_read(0);
      do_fill(1'b0);
      wait_all_done();
   endtask

   // long receiver hold while requests keep coming, so the input backs up
   task automatic test_backpressure();
      req_gaps     = 1'b0;
      rsp_gaps     = 1'b0;
      rsp_hold_len = 200;
      for (int i = 0; i < 8; i++) begin
         if (i % 2 == 0) do_pixel(int'($urandom_range(0, SCREEN_W - 1)),
                                  int'($urandom_range(0, SCREEN_H - 1)), 1'b1);
         else do_read(int'($urandom_range(0, STORE_SIZE - 1)));
      end
      wait_all_done();
   endtask

   task automatic test_random(input int n_items, input bit with_idle);
      plot_request_type r;
      int pick, gx, gy, idx;
      req_gaps = with_idle;
      rsp_gaps = with_idle;
      for (int i = 0; i < n_items; i++) begin
         r    = random_fields();
         pick = int'($urandom_range(0, 99));
         if (pick < 2) begin
            r.cmd      = CMD_FILL;
            r.pixel_on = ($urandom_range(0, 3) == 0);
         end else if (pick < 30) begin
            r.cmd = CMD_PIXEL;
            if ($urandom_range(0, 6) != 0) begin
               gx      = int'($urandom_range(0, SCREEN_W - 1));
               gy      = int'($urandom_range(0, SCREEN_H - 1));
               r.pos_x = gx[9:0];
               r.pos_y = gy[9:0];
               last_x  = gx;
               last_y  = gy & ~7;
            end
         end else if (pick < 55) begin
            r.cmd = CMD_GLYPH;
            if ($urandom_range(0, 6) != 0) begin
               gx      = int'($urandom_range(0, SCREEN_W + 6)) - 6;
               gy      = int'($urandom_range(0, SCREEN_H + 7)) - 7;
               r.pos_x = gx[9:0];
               r.pos_y = gy[9:0];
               last_x  = gx;
               last_y  = gy;
            end
            if ($urandom_range(0, 9) < 7) r.char_code = 8'($urandom_range(8'h20, 8'h7A));
         end else begin
            r.cmd = CMD_READ;
            if ($urandom_range(0, 1) == 0) begin
               idx = last_x + int'($urandom_range(0, 5))
                   + ((last_y + int'($urandom_range(0, 7))) / 8) * SCREEN_W;
               if (idx < 0 || idx >= STORE_SIZE) idx = int'($urandom_range(0, STORE_SIZE - 1));
               r.byte_index = idx[9:0];
            end
         end
         send_request(r);
      end
      wait_all_done();
   endtask

   initial begin : rsp_driver
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len > 0) begin
            n            = rsp_hold_len;
            rsp_hold_len = 0;
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end else if (rsp_gaps && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 8)) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      plot_response_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("ERROR: response with none pending, read_data %02h is_read %0b",
                        rsp_read_data, rsp_is_read);
         end else begin
            want = pending_rsp.pop_front();
            rsp_checked++;
            if (rsp_read_data !== want.read_data || rsp_is_read !== want.is_read) begin
               err_count++;
               if (err_count <= 10)
                  $display("ERROR: response %0d read_data exp %02h got %02h, is_read exp %0b got %0b",
                           rsp_checked, want.read_data, rsp_read_data, want.is_read, rsp_is_read);
            end
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_PIXEL;
      req_pos_x      = '0;
      req_pos_y      = '0;
      req_pixel_on   = 1'b0;
      req_char_code  = '0;
      req_byte_index = '0;
      foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      test_cleared_store();
      test_pixel_edges();
      test_glyph_cells();
      test_fill_store();
      test_backpressure();
      test_random(450, 1'b1);
      test_random(100, 1'b0);

      repeat (40) @(posedge clock);
      err_count += pending_rsp.size();
      $display("Covered %0d pixel, %0d glyph, %0d fill and %0d read requests",
               cmd_count[CMD_PIXEL], cmd_count[CMD_GLYPH], cmd_count[CMD_FILL],
               cmd_count[CMD_READ]);
      $display("%0d responses compared, %0d errors", rsp_checked, err_count);
      if (err_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/pftp_pkg.sv
hw/rtl/pftp_op_gen.sv
hw/rtl/page_framebuffer_text_plotter_unit.sv
tb/tb.sv
